[rtl/core/pmsf_pkg.sv]
// Shared types, sizes and codes for the minimum spanning forest core.
// No dependencies; the compare unit and the core in rtl/core import this package.
package pmsf_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VIDX_W + 1;
  localparam int CELL_W       = 2 * VIDX_W;
  localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
  localparam int WEIGHT_W     = 31;
  localparam int MODE_W       = 2;

  // Infinity is the all-ones weight; an absent edge is stored as infinity
  localparam logic [WEIGHT_W-1:0] WEIGHT_INF = {WEIGHT_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [VIDX_W-1:0]   from_vertex;
    logic [VIDX_W-1:0]   to_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [VIDX_W-1:0]   start_vertex;
  } pmsf_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              has_parent;
    logic [VIDX_W-1:0] parent_vertex;
    logic              last;
  } pmsf_out_t;

  // Request into the shared compare unit
  typedef struct packed {
    logic [WEIGHT_W-1:0] cand_w;
    logic [WEIGHT_W-1:0] ref_key;
    logic                cand_ok;
    logic                sel_ok;
    logic                found;
    logic [WEIGHT_W-1:0] best_key;
  } pmsf_cmp_req_t;

  // Answer from the shared compare unit
  typedef struct packed {
    logic                relax;
    logic                take;
    logic [WEIGHT_W-1:0] new_key;
  } pmsf_cmp_res_t;

  // Clamp the vertex count register to 1..MAX_VERTICES
  function automatic logic [VCNT_W-1:0] live_count(input logic [VCNT_W-1:0] cnt);
    logic [VCNT_W-1:0] n;
    n = cnt;
    if (cnt == '0) n = VCNT_W'(1);
    if (cnt > VCNT_W'(MAX_VERTICES)) n = VCNT_W'(MAX_VERTICES);
    return n;
  endfunction

endpackage

[rtl/core/pmsf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pmsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pmsf_cmp_unit.sv]
// Shared compare unit: relaxes a key against a candidate weight and
// tracks the running minimum for the next vertex. Depends on pmsf_pkg.
module pmsf_cmp_unit
  import pmsf_pkg::*;
(
  input  pmsf_cmp_req_t req,
  output pmsf_cmp_res_t res
);

  logic                relax;
  logic [WEIGHT_W-1:0] new_key;

  // Keep the smaller value; only a strictly smaller candidate wins
  assign relax   = req.cand_ok && (req.cand_w < req.ref_key);
  assign new_key = relax ? req.cand_w : req.ref_key;

  // Take the element when it beats the best so far; earlier index wins ties
  assign res.relax   = relax;
  assign res.new_key = new_key;
  assign res.take    = req.sel_ok && (!req.found || (new_key < req.best_key));

endmodule

[rtl/core/prim_minimum_spanning_forest_core.sv]
// Prim minimum spanning forest core over a 64x64 adjacency RAM.
// Add edge: read and compare, then a second write on a drop; clear sweeps every cell to infinity.
// Run with n vertices: initialize each vertex, then a mark step and a relax-and-select
// pass per removed vertex but the last, a final mark, then a sweep of n results.
// Results appear one per cycle on out_valid, the last in the first idle cycle; no stall.
// After reset the adjacency RAM is swept to empty with busy high.
module prim_minimum_spanning_forest_core
  import pmsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pmsf_in_t          in_item,
  output logic              out_valid,
  output pmsf_out_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLEAR   = 3'd1;
  localparam logic [2:0] S_ADD_CMP = 3'd2;
  localparam logic [2:0] S_ADD_WR2 = 3'd3;
  localparam logic [2:0] S_INIT    = 3'd4;
  localparam logic [2:0] S_MARK    = 3'd5;
  localparam logic [2:0] S_RELAX   = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [VCNT_W-1:0]       vcount_r;
  pmsf_in_t                item_r, item_nxt;
  logic [VCNT_W-1:0]       n_r, n_nxt;
  logic [CELL_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [VCNT_W-1:0]       idx_r, idx_nxt;
  logic                    p_v_r, p_v_nxt;
  logic [VIDX_W-1:0]       p_idx_r, p_idx_nxt;
  logic [VIDX_W-1:0]       u_r, u_nxt;
  logic                    found_r, found_nxt;
  logic [WEIGHT_W-1:0]     best_key_r, best_key_nxt;
  logic [VIDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [VCNT_W-1:0]       removed_r, removed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pmsf_out_t               out_item_r, out_item_nxt;

  logic                accept;
  logic                edge_we;
  logic [CELL_W-1:0]   edge_waddr, edge_raddr;
  logic [WEIGHT_W-1:0] edge_wdata, edge_rdata;
  logic                key_we;
  logic [VIDX_W-1:0]   key_waddr;
  logic [WEIGHT_W-1:0] key_wdata, key_rdata;
  logic                par_we;
  logic [VIDX_W-1:0]   par_waddr;
  logic [VCNT_W-1:0]   par_wdata, par_rdata;
  logic                tree_we;
  logic [VIDX_W-1:0]   tree_waddr;
  logic                tree_wdata, tree_rdata;
  logic                p_last;
  pmsf_cmp_req_t       cmp_req;
  pmsf_cmp_res_t       cmp_res;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign p_last    = ({1'b0, p_idx_r} == (n_r - VCNT_W'(1)));

  // Adjacency store: weight per cell, infinity marks no edge
  pmsf_ram #(.WIDTH(WEIGHT_W), .DEPTH(CELLS)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // Best key per vertex
  pmsf_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_VERTICES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (idx_r[VIDX_W-1:0]),
    .rdata (key_rdata)
  );

  // Parent per vertex, stored as parent index plus one, zero for a root
  pmsf_ram #(.WIDTH(VCNT_W), .DEPTH(MAX_VERTICES)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (idx_r[VIDX_W-1:0]),
    .rdata (par_rdata)
  );

  // Tree membership per vertex
  pmsf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (idx_r[VIDX_W-1:0]),
    .rdata (tree_rdata)
  );

  pmsf_cmp_unit u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  // Feed the compare unit: edge merge in add mode, relax and select in a run
  always_comb begin
    if (state_r == S_ADD_CMP) begin
      cmp_req.cand_w  = item_r.edge_weight;
      cmp_req.ref_key = edge_rdata;
      cmp_req.cand_ok = 1'b1;
      cmp_req.sel_ok  = 1'b0;
    end else begin
      cmp_req.cand_w  = edge_rdata;
      cmp_req.ref_key = key_rdata;
      cmp_req.cand_ok = !tree_rdata;
      cmp_req.sel_ok  = !tree_rdata;
    end
    cmp_req.found    = found_r;
    cmp_req.best_key = best_key_r;
  end

  // Memory ports
  always_comb begin
    edge_raddr = (state_r == S_RELAX) ? {u_r, idx_r[VIDX_W-1:0]}
                                      : {in_item.from_vertex, in_item.to_vertex};
    edge_we    = 1'b0;
    edge_waddr = {item_r.from_vertex, item_r.to_vertex};
    edge_wdata = item_r.edge_weight;
    key_we     = 1'b0;
    key_waddr  = p_idx_r;
    key_wdata  = cmp_res.new_key;
    par_we     = 1'b0;
    par_waddr  = p_idx_r;
    par_wdata  = {1'b0, u_r} + VCNT_W'(1);
    tree_we    = 1'b0;
    tree_waddr = u_r;
    tree_wdata = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_cnt_r;
        edge_wdata = WEIGHT_INF;
      end
      S_ADD_CMP: begin
        edge_we = cmp_res.relax;
      end
      S_ADD_WR2: begin
        edge_we    = 1'b1;
        edge_waddr = {item_r.to_vertex, item_r.from_vertex};
      end
      S_INIT: begin
        key_we     = 1'b1;
        key_waddr  = idx_r[VIDX_W-1:0];
        key_wdata  = ({1'b0, item_r.start_vertex} == idx_r) ? '0 : WEIGHT_INF;
        par_we     = 1'b1;
        par_waddr  = idx_r[VIDX_W-1:0];
        par_wdata  = '0;
        tree_we    = 1'b1;
        tree_waddr = idx_r[VIDX_W-1:0];
        tree_wdata = 1'b0;
      end
      S_MARK: begin
        tree_we = 1'b1;
      end
      S_RELAX: begin
        key_we = p_v_r && cmp_res.relax;
        par_we = p_v_r && cmp_res.relax;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    n_nxt         = n_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_nxt       = idx_r;
    p_v_nxt       = 1'b0;
    p_idx_nxt     = p_idx_r;
    u_nxt         = u_r;
    found_nxt     = found_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    removed_nxt   = removed_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          unique case (in_item.mode)
            MODE_ADD:   state_nxt = S_ADD_CMP;
            MODE_CLEAR: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
            end
            MODE_RUN: begin
              state_nxt   = S_INIT;
              idx_nxt     = '0;
              n_nxt       = live_count(vcount_r);
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == {CELL_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_ADD_CMP: begin
        state_nxt = cmp_res.relax ? S_ADD_WR2 : S_IDLE;
      end
      S_ADD_WR2: begin
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        idx_nxt = idx_r + VCNT_W'(1);
        if (idx_r == n_r - VCNT_W'(1)) begin
          // Start out of range: every key is infinity, vertex zero goes first
          u_nxt       = ({1'b0, item_r.start_vertex} < n_r) ? item_r.start_vertex : '0;
          removed_nxt = '0;
          state_nxt   = S_MARK;
        end
      end
      S_MARK: begin
        removed_nxt      = removed_r + VCNT_W'(1);
        idx_nxt          = '0;
        found_nxt        = 1'b0;
        state_nxt        = (removed_r + VCNT_W'(1) == n_r) ? S_OUT : S_RELAX;
      end
      S_RELAX: begin
        // Issue one vertex a cycle; evaluate it when the RAM data returns
        if (idx_r < n_r) begin
          idx_nxt   = idx_r + VCNT_W'(1);
          p_v_nxt   = 1'b1;
          p_idx_nxt = idx_r[VIDX_W-1:0];
        end
        if (p_v_r) begin
          if (cmp_res.take) begin
            found_nxt    = 1'b1;
            best_key_nxt = cmp_res.new_key;
            best_idx_nxt = p_idx_r;
          end
          if (p_last) begin
            u_nxt     = cmp_res.take ? p_idx_r : best_idx_r;
            p_v_nxt   = 1'b0;
            state_nxt = S_MARK;
          end
        end
      end
      S_OUT: begin
        if (idx_r < n_r) begin
          idx_nxt   = idx_r + VCNT_W'(1);
          p_v_nxt   = 1'b1;
          p_idx_nxt = idx_r[VIDX_W-1:0];
        end
        if (p_v_r) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.vertex_index  = p_idx_r;
          out_item_nxt.has_parent    = (par_rdata != '0);
          out_item_nxt.parent_vertex = (par_rdata != '0) ?
                                       VIDX_W'(par_rdata - VCNT_W'(1)) : '0;
          out_item_nxt.last          = p_last;
          if (p_last) begin
            p_v_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers; reset starts the sweep that empties the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      vcount_r    <= VCNT_W'(MAX_VERTICES);
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      removed_r   <= '0;
      n_r         <= VCNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      p_v_r       <= p_v_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      removed_r   <= removed_nxt;
      n_r         <= n_nxt;
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    p_idx_r    <= p_idx_nxt;
    u_r        <= u_nxt;
    best_key_r <= best_key_nxt;
    best_idx_r <= best_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // A result transfer only follows the output sweep
  a_out_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_OUT))
    else $error("result strobe outside the output sweep");

  // The final result ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("results continue after the last vertex");

  // An accepted run enters initialization
  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.mode == MODE_RUN)) |=> (state_r == S_INIT))
    else $error("run transfer did not start initialization");

  // Each removal advances the removal count by one
  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |=> (removed_r == $past(removed_r) + VCNT_W'(1)))
    else $error("removal count did not advance");

endmodule

[bench/prim_minimum_spanning_forest_core_tb.sv]
// Self-checking bench for prim_minimum_spanning_forest_core: edge loads, clears and forest runs.
// Depends on pmsf_pkg for the item types and mode codes; a tracker class predicts each report.
module prim_minimum_spanning_forest_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmsf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 4400;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 200;

  // Mirror of the adjacency store and the queue of predecessor reports still owed
  class pmsf_forest_board;
    bit                  linked [CELLS];
    logic [WEIGHT_W-1:0] link_w [CELLS];
    logic [VCNT_W-1:0]   vertex_count;
    pmsf_out_t           parent_reports_q [$];
    int                  errors;

    function new();
      vertex_count = VCNT_W'(MAX_VERTICES);
      errors = 0;
      foreach (linked[i]) linked[i] = 1'b0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t ERROR %s", $time, msg);
    endfunction

    // Keep the smaller weight when a pair is loaded again
    function void store_link(int a, int b, logic [WEIGHT_W-1:0] w);
      int slot;
      slot = a * MAX_VERTICES + b;
      if (!linked[slot] || w < link_w[slot]) begin
        link_w[slot] = w;
        linked[slot] = 1'b1;
      end
    endfunction

    // Prim over the live vertices; unreachable vertices become roots
    function void grow_forest(int root);
      logic [WEIGHT_W-1:0] key [MAX_VERTICES];
      bit                  taken [MAX_VERTICES];
      int                  parent [MAX_VERTICES];
      int                  n, u, slot;
      pmsf_out_t           rep;
      n = int'(vertex_count);
      if (n == 0) n = 1;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      for (int i = 0; i < n; i++) begin
        key[i]    = (i == root) ? '0 : WEIGHT_INF;
        taken[i]  = 1'b0;
        parent[i] = -1;
      end
      for (int step = 0; step < n; step++) begin
        u = -1;
        for (int i = 0; i < n; i++)
          if (!taken[i] && (u < 0 || key[i] < key[u])) u = i;
        taken[u] = 1'b1;
        // relax only on a strictly smaller weight
        for (int i = 0; i < n; i++) begin
          slot = u * MAX_VERTICES + i;
          if (!taken[i] && linked[slot] && link_w[slot] < key[i]) begin
            key[i]    = link_w[slot];
            parent[i] = u;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        rep.vertex_index  = VIDX_W'(i);
        rep.has_parent    = (parent[i] >= 0);
        rep.parent_vertex = (parent[i] >= 0) ? VIDX_W'(parent[i]) : '0;
        rep.last          = (i == n - 1);
        parent_reports_q  = {parent_reports_q, rep};
      end
    endfunction

    function void note_item(pmsf_in_t it);
      case (it.mode)
        MODE_ADD: begin
          store_link(int'(it.from_vertex), int'(it.to_vertex), it.edge_weight);
          store_link(int'(it.to_vertex), int'(it.from_vertex), it.edge_weight);
        end
        MODE_CLEAR: foreach (linked[i]) linked[i] = 1'b0;
        MODE_RUN:   grow_forest(int'(it.start_vertex));
        default: ;
      endcase
    endfunction

    function void check_result(pmsf_out_t got);
      pmsf_out_t want;
      if (parent_reports_q.size() == 0) begin
        flag($sformatf("unexpected report for vertex %0d", got.vertex_index));
        return;
      end
      want = parent_reports_q.pop_front();
      if (got.vertex_index !== want.vertex_index || got.has_parent !== want.has_parent ||
          got.parent_vertex !== want.parent_vertex || got.last !== want.last)
        flag($sformatf("expected v=%0d hp=%0d p=%0d last=%0d, got v=%0d hp=%0d p=%0d last=%0d",
                       want.vertex_index, want.has_parent, want.parent_vertex, want.last,
                       got.vertex_index, got.has_parent, got.parent_vertex, got.last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  pmsf_in_t          in_item = '0;
  logic              out_valid;
  pmsf_out_t         out_item;
  logic              cfg_wr_en = 1'b0;
  logic [VCNT_W-1:0] cfg_wr_data = '0;

  pmsf_forest_board board = new();
  int               idle_pct = 27;

  prim_minimum_spanning_forest_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Check every report at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) board.check_result(out_item);
  end

  function automatic pmsf_in_t make_item(logic [MODE_W-1:0] mode, int a, int b,
                                         logic [WEIGHT_W-1:0] w, int root);
    pmsf_in_t it;
    it.mode         = mode;
    it.from_vertex  = VIDX_W'(a);
    it.to_vertex    = VIDX_W'(b);
    it.edge_weight  = w;
    it.start_vertex = VIDX_W'(root);
    return it;
  endfunction

  // Mostly tiny weights so ties are common, plus full-width and boundary values
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return WEIGHT_W'($urandom_range(7));
    if (pick < 8) return WEIGHT_W'($urandom);
    if (pick == 8) return WEIGHT_INF;
    return $urandom_range(1) ? WEIGHT_INF - WEIGHT_W'(1) : '0;
  endfunction

  function automatic int rand_vertex(int n);
    if ($urandom_range(6) == 0) return $urandom_range(63);
    return $urandom_range(n - 1);
  endfunction

  // Present one item and hold it until the transfer happens
  task automatic send_item(pmsf_in_t it);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
  endtask

  // Drop start, wait for all reports, then let a clear or run finish
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (board.parent_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(logic [VCNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.vertex_count = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int issued, scen, v, n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the post-reset sweep is done
    @(posedge clk);
    while (busy) @(posedge clk);
    write_count(VCNT_W'(5));

    // Directed: ties, infinite and maximal weights, repeats, self loop, far endpoints
    send_item(make_item(MODE_ADD, 0, 1, WEIGHT_W'(10), 0));
    send_item(make_item(MODE_ADD, 1, 2, WEIGHT_W'(10), 0));
    send_item(make_item(MODE_ADD, 0, 2, WEIGHT_W'(10), 0));
    send_item(make_item(MODE_ADD, 2, 3, WEIGHT_INF, 0));
    send_item(make_item(MODE_ADD, 3, 4, '0, 0));
    send_item(make_item(MODE_ADD, 1, 1, '0, 0));
    send_item(make_item(MODE_ADD, 0, 1, WEIGHT_W'(20), 0));
    send_item(make_item(MODE_ADD, 1, 0, WEIGHT_W'(5), 0));
    send_item(make_item(MODE_ADD, 4, 63, '0, 0));
    send_item(make_item(MODE_ADD, 63, 62, WEIGHT_INF - WEIGHT_W'(1), 63));
    send_item(make_item(MODE_NONE, 63, 63, WEIGHT_INF, 63));
    send_item(make_item(MODE_RUN, 63, 63, WEIGHT_INF, 0));
    send_item(make_item(MODE_RUN, 0, 0, '0, 4));
    send_item(make_item(MODE_RUN, 0, 0, '0, 63));
    send_item(make_item(MODE_CLEAR, 63, 63, WEIGHT_INF, 63));
    send_item(make_item(MODE_RUN, 0, 0, '0, 2));
    send_item(make_item(MODE_ADD, 0, 4, WEIGHT_W'(7), 0));
    send_item(make_item(MODE_ADD, 3, 4, WEIGHT_W'(1000), 0));
    send_item(make_item(MODE_RUN, 0, 0, '0, 3));

    // Random graphs, one vertex count per batch; extremes of the count first
    issued = 0;
    scen   = 0;
    while (issued < RANDOM_ITEMS) begin
      settle();
      idle_pct = (issued < 67) ? 27 : (issued < 134) ? 68 : 0;
      case (scen)
        0: v = 0;
        1: v = 127;
        2: v = 64;
        3: v = 1;
        4: v = 65;
        default: begin
          v = $urandom_range(19);
          if (v < 16) v = $urandom_range(12, 1);
          else if (v < 18) v = $urandom_range(40, 13);
          else if (v == 18) v = 64;
          else v = $urandom_range(127, 65);
        end
      endcase
      write_count(VCNT_W'(v));
      n = (v == 0) ? 1 : (v > MAX_VERTICES) ? MAX_VERTICES : v;
      // a run on the old graph sees edges that a new count exposes
      if ($urandom_range(3) == 0) begin
        send_item(make_item(MODE_RUN, $urandom_range(63), $urandom_range(63), WEIGHT_W'($urandom),
                            rand_vertex(n)));
        issued++;
      end
      if ($urandom_range(9) < 7) begin
        send_item(make_item(MODE_CLEAR, $urandom_range(63), $urandom_range(63),
                            WEIGHT_W'($urandom), $urandom_range(63)));
        issued++;
      end
      repeat ($urandom_range(14, 2)) begin
        if ($urandom_range(9) == 0)
          send_item(make_item(MODE_NONE, $urandom_range(63), $urandom_range(63),
                              WEIGHT_W'($urandom), $urandom_range(63)));
        send_item(make_item(MODE_ADD, rand_vertex(n), rand_vertex(n), rand_weight(),
                            $urandom_range(63)));
        issued++;
      end
      repeat ($urandom_range(2, 1)) begin
        send_item(make_item(MODE_RUN, $urandom_range(63), $urandom_range(63), WEIGHT_W'($urandom),
                            rand_vertex(n)));
        issued++;
      end
      scen++;
    end

    settle();
    if (board.parent_reports_q.size() != 0)
      board.flag($sformatf("%0d reports never arrived", board.parent_reports_q.size()));
    if (board.errors == 0) begin
      $display("prim_minimum_spanning_forest_core_tb: PASS");
    end else begin
      $display("prim_minimum_spanning_forest_core_tb: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(64'd100_000_000);
    $display("prim_minimum_spanning_forest_core_tb: FAIL");
    $finish;
  end

endmodule
